// ===== rtl/cott_pkg.sv =====
// Package with constants, payload types and controller/datapath interface structs.
`default_nettype none
package cott_pkg;
    localparam int MaxChunks  = 256;
    localparam int PosBits    = 48;
    localparam int KeyPrefix  = 16;
    localparam int IdxBits    = $clog2(MaxChunks);
    localparam int CntBits    = IdxBits + 1;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_UPDATE = 3'd1;
    localparam logic [2:0] MODE_HAS    = 3'd2;
    localparam logic [2:0] MODE_KEYPOS = 3'd3;
    localparam logic [2:0] MODE_TOFILE = 3'd4;
    localparam logic [2:0] MODE_TOLOG  = 3'd5;
    localparam logic [2:0] MODE_SIZE   = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_GAP     = 3'd1;
    localparam logic [2:0] ST_OVERLAP = 3'd2;
    localparam logic [2:0] ST_NOTFND  = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_NEG     = 3'd6;

    localparam logic REG_FRAME_WRAPPED = 1'b0;
    localparam logic REG_FIRST_OFFSET  = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        partition_index;
        logic [PosBits-1:0] claim_offset;
        logic [PosBits-1:0] elem_pos;
        logic [PosBits-1:0] element_length;
        logic [3:0]         length_field_bytes;
        logic [63:0]        key_high;
        logic [63:0]        key_low;
        logic [PosBits-1:0] query_offset;
        logic [PosBits-1:0] query_size;
        logic               is_final;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic               found;
        logic [PosBits-1:0] result_position;
        logic [63:0]        key_high_out;
        logic [63:0]        key_low_out;
        logic [16:0]        indexed_partitions;
    } t_out;

    // Commands from controller to datapath.
    typedef struct packed {
        logic               load;      // capture the input transaction
        logic               rd_last;   // read the last entry
        logic               rd_cur;    // read the entry at the cursor
        logic               step;      // apply seek decision on the read entry
        logic               finish;    // compute and register the result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic seek_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/cott_ctrl.sv =====
// Controller state machine sequencing reads, cursor walks and result delivery.
`default_nettype none
module cott_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_out_stall,
    output logic               o_valid,
    input  wire logic          i_seek,
    input  wire cott_pkg::t_sts i_sts,
    output cott_pkg::t_cmd     o_cmd
);
    import cott_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_SEEK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_last = !i_seek;
                o_cmd.rd_cur  = i_seek;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                n_state = i_seek ? S_SEEK : S_FIN;
            end
            S_SEEK: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.seek_done ? S_FIN : S_WAIT;
                o_cmd.rd_cur = !i_sts.seek_done;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

// ===== rtl/cott_dp.sv =====
// Datapath: chunk table memory, cursor, counters and the translation arithmetic.
`default_nettype none
module cott_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [31:0]     i_cfg_data,
    input  wire cott_pkg::t_in   i_data,
    input  wire cott_pkg::t_cmd  i_cmd,
    output cott_pkg::t_sts       o_sts,
    output logic                 o_seek,
    output cott_pkg::t_out       o_data
);
    import cott_pkg::*;

    typedef struct packed {
        logic [PosBits-1:0] lo;
        logic [PosBits-1:0] fp;
        logic [PosBits-1:0] sz;
        logic               cp;
        logic [63:0]        kh;
        logic [63:0]        kl;
    } t_ent;

    t_ent               r_mem [MaxChunks];
    t_ent               r_rd;
    t_in                r_in;
    logic [CntBits-1:0] r_count;
    logic [IdxBits-1:0] r_cursor;
    logic [IdxBits-1:0] r_scan;
    logic [1:0]         r_dir;      // 0 undecided, 1 back, 2 forward, 3 walk over
    logic [16:0]        r_parts;
    logic               r_fw;
    logic [31:0]        r_ffo;
    t_out               r_out;

    logic               is_query, empty;
    logic [IdxBits-1:0] last_idx;
    logic [PosBits-1:0] base, other;
    logic [PosBits:0]   b_end, q_end, q_ext;
    logic               below, past;

    assign empty    = (r_count == '0);
    assign last_idx = IdxBits'(r_count - 1'b1);
    assign is_query = (r_in.mode == MODE_HAS) || (r_in.mode == MODE_KEYPOS) ||
                      (r_in.mode == MODE_TOFILE) || (r_in.mode == MODE_TOLOG);
    assign o_seek   = is_query && !empty;

    // Seek comparisons on the entry just read.
    assign base  = (r_in.mode == MODE_TOLOG) ? r_rd.fp : r_rd.lo;
    assign other = (r_in.mode == MODE_TOLOG) ? r_rd.lo : r_rd.fp;
    assign b_end = {1'b0, base} + {1'b0, r_rd.sz};
    assign q_ext = {1'b0, r_in.query_offset};
    assign q_end = q_ext + {1'b0, r_in.query_size};
    assign below = base > r_in.query_offset;
    assign past  = b_end <= q_ext;

    // Walk state: direction decided on the cursor entry, one entry per step.
    // A walk that runs off the table end leaves the cursor where it was, so the
    // cursor entry is read once more before the result is formed.
    logic               stop, miss;
    logic [IdxBits-1:0] nxt;
    always_comb begin
        stop = 1'b1;
        nxt  = r_scan;
        case (r_dir)
            2'd0: begin
                if (below && r_scan != '0) begin
                    stop = 1'b0; nxt = r_scan - 1'b1;
                end else if (!below && past &&
                             ({1'b0, r_scan} + 1'b1) < r_count) begin
                    stop = 1'b0; nxt = r_scan + 1'b1;
                end
            end
            2'd1: begin
                if (below && r_scan != '0) begin
                    stop = 1'b0; nxt = r_scan - 1'b1;
                end
            end
            2'd2: begin
                if (past && ({1'b0, r_scan} + 1'b1) < r_count) begin
                    stop = 1'b0; nxt = r_scan + 1'b1;
                end
            end
            default: ;
        endcase
        miss = stop && (((r_dir == 2'd1) && below) || ((r_dir == 2'd2) && past));
        if (miss) nxt = r_cursor;
    end
    assign o_sts.seek_done = stop && !miss;

    // Registered table read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_last) r_rd <= r_mem[last_idx];
        else if (i_cmd.rd_cur) r_rd <= r_mem[i_cmd.step ? nxt : r_cursor];
    end

    // Append and update computation on the last entry.
    logic [PosBits-1:0] expct, app_pos, app_sz;
    logic [2:0]         app_st;
    logic               app_ok;
    logic [PosBits:0]   old_end;
    always_comb begin
        expct   = empty ? '0 : PosBits'(r_rd.lo + r_rd.sz);
        app_st  = (r_in.claim_offset > expct) ? ST_GAP :
                  (r_in.claim_offset < expct) ? ST_OVERLAP : ST_OK;
        app_ok  = 1'b1;
        app_pos = r_in.elem_pos;
        app_sz  = '0;
        if (r_fw) begin
            app_pos = r_in.elem_pos -
                      (PosBits'(KeyPrefix) + PosBits'(r_in.length_field_bytes));
        end else begin
            app_sz = r_in.element_length;
            if (r_ffo != '0 && empty) begin
                if (r_in.element_length < PosBits'(r_ffo)) begin
                    app_ok = 1'b0;
                end else begin
                    app_pos = r_in.elem_pos + PosBits'(r_ffo);
                    app_sz  = r_in.element_length - PosBits'(r_ffo);
                end
            end
        end
        old_end = {1'b0, r_rd.fp} + {1'b0, r_rd.sz};
    end

    // Hit test for the selected chunk.
    logic hit;
    always_comb begin
        if (r_in.mode == MODE_KEYPOS) begin
            hit = !below;
            if (hit && b_end < q_end && (b_end < q_ext || r_rd.cp)) hit = 1'b0;
        end else begin
            hit = !below && (b_end >= q_ext);
        end
    end

    // Control state, configuration, cursor and counter updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_parts  <= '0;
            r_fw     <= 1'b0;
            r_ffo    <= '0;
            r_dir    <= '0;
            r_scan   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WRAPPED) r_fw <= i_cfg_data[0];
                else r_ffo <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_dir  <= '0;
                r_scan <= r_cursor;
            end
            if (i_cmd.step) begin
                r_scan <= nxt;
                if (miss) r_dir <= 2'd3;
                else if (r_dir == 2'd0) r_dir <= below ? 2'd1 : 2'd2;
            end
            if (i_cmd.finish) begin
                if (is_query && !empty) r_cursor <= r_scan;
                if (r_in.mode == MODE_APPEND && r_count != CntBits'(MaxChunks) && app_ok) begin
                    r_count <= r_count + 1'b1;
                    r_parts <= {1'b0, r_in.partition_index} + 17'd1;
                end
            end
        end
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_in.mode == MODE_APPEND && r_count != CntBits'(MaxChunks) && app_ok) begin
                r_mem[IdxBits'(r_count)] <= '{lo: expct, fp: app_pos, sz: app_sz,
                    cp: !r_fw, kh: r_in.key_high, kl: r_in.key_low};
            end else if (r_in.mode == MODE_UPDATE && !empty && !r_rd.cp &&
                         {1'b0, r_in.elem_pos} >= old_end) begin
                r_mem[last_idx] <= '{lo: r_rd.lo, fp: r_rd.fp,
                    sz: r_in.elem_pos - r_rd.fp, cp: r_in.is_final,
                    kh: r_rd.kh, kl: r_rd.kl};
            end
        end
    end

    // Result of the current transaction.
    t_out n_out;
    always_comb begin
        n_out = '0;
        n_out.indexed_partitions = r_parts;
        case (r_in.mode)
            MODE_APPEND: begin
                if (r_count == CntBits'(MaxChunks)) n_out.status = ST_FULL;
                else if (!app_ok) n_out.status = ST_NEG;
                else begin
                    n_out.status = app_st;
                    n_out.indexed_partitions = {1'b0, r_in.partition_index} + 17'd1;
                end
            end
            MODE_SIZE: n_out.result_position = expct;
            MODE_UPDATE: begin
                if (empty) n_out.status = ST_EMPTY;
            end
            MODE_HAS, MODE_KEYPOS, MODE_TOFILE, MODE_TOLOG: begin
                if (empty) n_out.status = ST_EMPTY;
                else begin
                    n_out.key_high_out = r_rd.kh;
                    n_out.key_low_out  = r_rd.kl;
                    n_out.found        = hit;
                    if (r_in.mode != MODE_HAS) begin
                        if (hit) n_out.result_position =
                            other + (r_in.query_offset - base);
                        else n_out.status = ST_NOTFND;
                    end
                end
            end
            default: ;
        endcase
    end

    // Input capture and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_data;
        if (i_cmd.finish) r_out <= n_out;
    end

    assign o_data = r_out;
endmodule
`default_nettype wire

// ===== rtl/chunk_offset_translation_table.sv =====
// Top level of the chunk offset translation table.
// Appends, updates, size queries and queries on an empty table read the last entry and
// form the result; table queries walk the cursor one entry per step from the cursor entry,
// and a walk that finds nothing reads the cursor entry again before the result is formed.
// Throughput: one transaction at a time; the next is taken the cycle after the result leaves.
// Synchronous active-low reset clears count, cursor, partition count and registers;
// the table itself is not cleared.
`default_nettype none
module chunk_offset_translation_table (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire cott_pkg::t_in    i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output cott_pkg::t_out        o_data,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data
);
    import cott_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic seek;

    cott_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_out_stall(i_stall), .o_valid(o_valid), .i_seek(seek),
        .i_sts(sts), .o_cmd(cmd)
    );

    cott_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_data(i_data),
        .i_cmd(cmd), .o_sts(sts), .o_seek(seek), .o_data(o_data)
    );

    // A new transaction is never taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result pending");
    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the chunk offset translation table.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import cott_pkg::*;

    localparam int CycleLimit = 4000000;
    localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

    // Clock, reset and ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_FRAME_WRAPPED;
    logic [31:0] i_cfg_data = '0;

    chunk_offset_translation_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the chunk table and its registers.
    logic [PosBits-1:0] tbl_logical [MaxChunks];
    logic [PosBits-1:0] tbl_filepos [MaxChunks];
    logic [PosBits-1:0] tbl_size [MaxChunks];
    logic               tbl_done [MaxChunks];
    logic [63:0]        tbl_key_hi [MaxChunks];
    logic [63:0]        tbl_key_lo [MaxChunks];
    int unsigned        tbl_count = 0;
    int unsigned        tbl_cursor = 0;
    logic [16:0]        parts_seen = '0;
    logic               cfg_frame_wrapped = 1'b0;
    logic [31:0]        cfg_first_offset = '0;

    t_out   expected_results[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    bit     quiet = 1'b0;
    int     rx_wait = 0;

    function automatic logic [PosBits-1:0] rand_pos();
        return PosBits'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Start of an entry in logical space or in file space.
    function automatic logic [PosBits-1:0] entry_start(int unsigned idx, bit by_file);
        return by_file ? tbl_filepos[idx] : tbl_logical[idx];
    endfunction

    // Exact end of an entry, one bit wider so that no sum wraps.
    function automatic logic [PosBits:0] entry_end(int unsigned idx, bit by_file);
        return {1'b0, entry_start(idx, by_file)} + {1'b0, tbl_size[idx]};
    endfunction

    // Walks the cursor toward the queried value one entry at a time.
    function automatic void walk_cursor(bit by_file, logic [PosBits-1:0] q);
        int unsigned c;
        c = tbl_cursor;
        if (entry_start(c, by_file) > q) begin
            for (int unsigned i = c; i > 0; i--) begin
                if (entry_start(i - 1, by_file) <= q) begin
                    tbl_cursor = i - 1;
                    break;
                end
            end
        end else if (entry_end(c, by_file) <= {1'b0, q}) begin
            for (int unsigned i = c + 1; i < tbl_count; i++) begin
                if (entry_end(i, by_file) > {1'b0, q}) begin
                    tbl_cursor = i;
                    break;
                end
            end
        end
    endfunction

    // Computes the result of one transaction and updates the shadow table.
    function automatic t_out translate_chunk(t_in x);
        t_out r;
        logic [PosBits-1:0] tail, pos, size, base;
        logic hit, ok, by_file;
        int unsigned l, c;
        r = '0;
        tail = '0;
        if (tbl_count > 0) begin
            l = tbl_count - 1;
            tail = tbl_logical[l] + tbl_size[l];
        end
        case (x.mode)
            MODE_APPEND: begin
                if (tbl_count >= MaxChunks) begin
                    r.status = ST_FULL;
                end else begin
                    pos = x.elem_pos;
                    size = '0;
                    ok = 1'b1;
                    if (x.claim_offset > tail) r.status = ST_GAP;
                    else if (x.claim_offset < tail) r.status = ST_OVERLAP;
                    if (cfg_frame_wrapped) begin
                        pos = pos - (PosBits'(KeyPrefix) + PosBits'(x.length_field_bytes));
                    end else begin
                        size = x.element_length;
                        if (cfg_first_offset != 0 && tbl_count == 0) begin
                            if (size < PosBits'(cfg_first_offset)) begin
                                ok = 1'b0;
                            end else begin
                                pos = pos + PosBits'(cfg_first_offset);
                                size = size - PosBits'(cfg_first_offset);
                            end
                        end
                    end
                    if (!ok) begin
                        r.status = ST_NEG;
                    end else begin
                        tbl_logical[tbl_count] = tail;
                        tbl_filepos[tbl_count] = pos;
                        tbl_size[tbl_count] = size;
                        tbl_done[tbl_count] = !cfg_frame_wrapped;
                        tbl_key_hi[tbl_count] = x.key_high;
                        tbl_key_lo[tbl_count] = x.key_low;
                        tbl_count++;
                        parts_seen = {1'b0, x.partition_index} + 17'd1;
                    end
                end
            end
            MODE_SIZE: r.result_position = tail;
            MODE_UPDATE, MODE_HAS, MODE_KEYPOS, MODE_TOFILE, MODE_TOLOG: begin
                if (tbl_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (x.mode == MODE_UPDATE) begin
                    if (!tbl_done[l] && {1'b0, x.elem_pos} >= entry_end(l, 1'b1)) begin
                        tbl_size[l] = x.elem_pos - tbl_filepos[l];
                        tbl_done[l] = x.is_final;
                    end
                end else begin
                    by_file = (x.mode == MODE_TOLOG);
                    walk_cursor(by_file, x.query_offset);
                    c = tbl_cursor;
                    base = entry_start(c, by_file);
                    r.key_high_out = tbl_key_hi[c];
                    r.key_low_out = tbl_key_lo[c];
                    if (x.mode == MODE_KEYPOS) begin
                        hit = base <= x.query_offset;
                        if (hit && entry_end(c, by_file) <
                                {1'b0, x.query_offset} + {1'b0, x.query_size}) begin
                            if (entry_end(c, by_file) < {1'b0, x.query_offset} || tbl_done[c])
                                hit = 1'b0;
                        end
                    end else begin
                        hit = base <= x.query_offset &&
                              entry_end(c, by_file) >= {1'b0, x.query_offset};
                    end
                    r.found = hit;
                    if (x.mode != MODE_HAS) begin
                        if (hit)
                            r.result_position = entry_start(c, !by_file) +
                                                (x.query_offset - base);
                        else
                            r.status = ST_NOTFND;
                    end
                end
            end
            default: ;
        endcase
        r.indexed_partitions = parts_seen;
        return r;
    endfunction

    // Sends one transaction, holding it until it is taken.
    task automatic send_item(t_in x, bit typed, t_out typed_result);
        int gap;
        t_out r;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = translate_chunk(x);
        expected_results.insert(expected_results.size(), typed ? typed_result : r);
    endtask

    // Register write while the block is idle.
    task automatic write_reg(logic idx, logic [31:0] value);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FRAME_WRAPPED) cfg_frame_wrapped = value[0];
        else cfg_first_offset = value;
    endtask

    function automatic t_in make_item(logic [2:0] mode, logic [15:0] part,
                                      logic [PosBits-1:0] body, logic [PosBits-1:0] fpos,
                                      logic [PosBits-1:0] elen, logic [3:0] lfb,
                                      logic [63:0] key, logic [PosBits-1:0] q,
                                      logic [PosBits-1:0] qs, logic fin);
        t_in x;
        x.mode = mode;
        x.partition_index = part;
        x.claim_offset = body;
        x.elem_pos = fpos;
        x.element_length = elen;
        x.length_field_bytes = lfb;
        x.key_high = key;
        x.key_low = ~key;
        x.query_offset = q;
        x.query_size = qs;
        x.is_final = fin;
        return x;
    endfunction

    function automatic logic [PosBits-1:0] tail_offset();
        if (tbl_count == 0) return '0;
        return tbl_logical[tbl_count - 1] + tbl_size[tbl_count - 1];
    endfunction

    function automatic logic [PosBits-1:0] last_end_pos();
        if (tbl_count == 0) return rand_pos() >> 8;
        return tbl_filepos[tbl_count - 1] + tbl_size[tbl_count - 1];
    endfunction

    // Draws one random transaction, mostly well formed against the table.
    function automatic t_in random_item();
        t_in x;
        int unsigned pick, i;
        logic [PosBits-1:0] base, span;
        pick = $urandom_range(0, 99);
        x = make_item(MODE_HAS, 16'($urandom), tail_offset(), '0,
                      PosBits'($urandom_range(0, 4095)), 4'($urandom_range(1, 9)),
                      rand_key(), '0, PosBits'($urandom_range(0, 64)),
                      1'($urandom_range(0, 1)));
        x.key_low = rand_key();
        x.elem_pos = last_end_pos() + PosBits'($urandom_range(0, 64));
        if (pick < 15) begin
            x.mode = MODE_APPEND;
            if ($urandom_range(0, 15) == 0) x.element_length = rand_pos();
        end else if (pick < 20) begin
            x.mode = MODE_APPEND;
            x.claim_offset = rand_pos();
            x.elem_pos = rand_pos();
        end else if (pick < 30) begin
            x.mode = MODE_UPDATE;
            x.elem_pos = last_end_pos() + PosBits'($urandom_range(0, 4096));
        end else if (pick < 34) begin
            x.mode = MODE_UPDATE;
            x.elem_pos = rand_pos();
        end else if (pick < 76) begin
            x.mode = 3'($urandom_range(MODE_HAS, MODE_TOLOG));
            if (tbl_count > 0) begin
                i = $urandom_range(0, tbl_count - 1);
                base = entry_start(i, x.mode == MODE_TOLOG);
                span = (tbl_size[i] < 5000) ? tbl_size[i] + 1 : 5000;
                x.query_offset = base + PosBits'($urandom_range(0, int'(span)));
            end
        end else if (pick < 86) begin
            x.mode = 3'($urandom_range(MODE_HAS, MODE_TOLOG));
            x.query_offset = rand_pos();
            x.query_size = rand_pos();
        end else if (pick < 92) begin
            x.mode = MODE_SIZE;
        end else begin
            x = make_item(3'($urandom), 16'($urandom), rand_pos(), rand_pos(), rand_pos(),
                          4'($urandom_range(1, 9)), rand_key(), rand_pos(), rand_pos(),
                          1'($urandom_range(0, 1)));
            x.key_low = rand_key();
        end
        return x;
    endfunction

    // Result side: random stalls and field-by-field comparison.
    always @(posedge i_clk) begin
        t_out want;
        int hold;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_data.status);
                    fail_count++;
                end
                if (o_data.found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, o_data.found);
                    fail_count++;
                end
                if (o_data.result_position !== want.result_position) begin
                    $display("%0t: result_position expected %h actual %h",
                             $time, want.result_position, o_data.result_position);
                    fail_count++;
                end
                if (o_data.key_high_out !== want.key_high_out) begin
                    $display("%0t: key_high_out expected %h actual %h",
                             $time, want.key_high_out, o_data.key_high_out);
                    fail_count++;
                end
                if (o_data.key_low_out !== want.key_low_out) begin
                    $display("%0t: key_low_out expected %h actual %h",
                             $time, want.key_low_out, o_data.key_low_out);
                    fail_count++;
                end
                if (o_data.indexed_partitions !== want.indexed_partitions) begin
                    $display("%0t: indexed_partitions expected %h actual %h",
                             $time, want.indexed_partitions, o_data.indexed_partitions);
                    fail_count++;
                end
            end
            hold = quiet ? 0 : $urandom_range(0, 11);
            rx_wait <= hold;
            i_stall <= (hold != 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= (rx_wait > 1);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed rows: a transaction, or a register write when is_cfg is set.
    typedef struct {
        bit          is_cfg;
        logic        reg_idx;
        logic [31:0] reg_val;
        t_in         item;
        bit          typed;
        t_out        result;
    } t_row;

    t_row directed[$];

    function automatic void add_row(t_in x, bit typed = 1'b0, logic [2:0] st = ST_OK);
        t_row row;
        row = '{1'b0, REG_FRAME_WRAPPED, '0, x, typed, '0};
        row.result.status = st;
        directed.insert(directed.size(), row);
    endfunction

    function automatic void add_cfg(logic idx, logic [31:0] value);
        t_row row;
        row = '{1'b1, idx, value, '0, 1'b0, '0};
        directed.insert(directed.size(), row);
    endfunction

    initial begin
        t_row row;
        // Empty table, unused mode and trimmed size below zero are read off directly.
        add_row(make_item(MODE_UPDATE, 0, 0, PosMax, 0, 1, 0, 0, 0, 1), 1'b1, ST_EMPTY);
        add_row(make_item(MODE_HAS, 0, 0, 0, 0, 1, 0, PosMax, 0, 0), 1'b1, ST_EMPTY);
        add_row(make_item(MODE_KEYPOS, 0, 0, 0, 0, 1, 0, 0, PosMax, 0), 1'b1, ST_EMPTY);
        add_row(make_item(MODE_TOFILE, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1, ST_EMPTY);
        add_row(make_item(MODE_TOLOG, 0, 0, 0, 0, 1, 0, PosMax, 0, 0), 1'b1, ST_EMPTY);
        add_row(make_item(MODE_SIZE, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1, ST_OK);
        add_row(make_item(3'd7, 16'hffff, PosMax, PosMax, PosMax, 9, '1, PosMax, PosMax, 1),
                1'b1, ST_OK);
        add_cfg(REG_FIRST_OFFSET, 32'hffff_ffff);
        add_row(make_item(MODE_APPEND, 16'h1234, 0, 100, 5, 2, '1, 0, 0, 0), 1'b1, ST_NEG);
        // The remaining rows go through the predictor.
        add_row(make_item(MODE_APPEND, 16'hffff, PosMax, PosMax, PosMax, 9, '1, 0, 0, 0));
        add_row(make_item(MODE_SIZE, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        add_row(make_item(MODE_UPDATE, 0, 0, PosMax, 0, 1, 0, 0, 0, 1));
        add_row(make_item(MODE_TOFILE, 0, 0, 0, 0, 1, 0, PosMax, 0, 0));
        add_row(make_item(MODE_KEYPOS, 0, 0, 0, 0, 1, 0, 0, PosMax, 0));
        add_row(make_item(MODE_TOLOG, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        add_cfg(REG_FRAME_WRAPPED, 32'd1);
        add_row(make_item(MODE_APPEND, 16'h0, 0, 0, 0, 9, 64'h0, 0, 0, 0));
        add_row(make_item(MODE_UPDATE, 0, 0, PosMax, 0, 1, 0, 0, 0, 0));
        add_row(make_item(MODE_TOFILE, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        add_row(make_item(MODE_TOLOG, 0, 0, 0, 0, 1, 0, PosMax, 0, 0));
        add_row(make_item(MODE_UPDATE, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        add_row(make_item(MODE_UPDATE, 0, 0, PosMax, 0, 1, 0, 0, 0, 1));
        add_row(make_item(MODE_HAS, 0, 0, 0, 0, 1, 0, PosMax, 0, 0));
        add_row(make_item(MODE_KEYPOS, 0, 0, 0, 0, 1, 0, PosMax, 1, 0));
        add_row(make_item(MODE_APPEND, 16'h5a5a, PosMax, 64, 0, 1, 64'ha5a5_5a5a_0f0f_f0f0,
                          0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            row = directed[n];
            if (row.is_cfg) write_reg(row.reg_idx, row.reg_val);
            else send_item(row.item, row.typed, row.result);
        end

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_FRAME_WRAPPED, 32'(phase % 2));
            case (phase)
                0: write_reg(REG_FIRST_OFFSET, 32'd0);
                1: write_reg(REG_FIRST_OFFSET, 32'hffff_ffff);
                default: write_reg(REG_FIRST_OFFSET, $urandom);
            endcase
            for (int k = 0; k < 350; k++) begin
                if (k % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
                send_item(random_item(), 1'b0, '0);
            end
        end

        @(posedge i_clk);
        i_valid <= 1'b0;
        quiet = 1'b1;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/cott_pkg.sv
rtl/cott_ctrl.sv
rtl/cott_dp.sv
rtl/chunk_offset_translation_table.sv
tb/sv/tb_top.sv
